// ----- rtl/psd_pkg.sv -----
// psd_pkg: request and result types, opcodes and configuration indexes
// shared by the power spectrum descriptor core
// no dependencies
package psd_pkg;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_READ    = 2'd2
  } opcode_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 2'd1;

  // squared-norm accumulator, wide enough for one term square on top of the limit
  localparam int unsigned NORM_W   = 120;
  localparam int unsigned NORM_SAT = 112;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         address;
    logic signed [31:0] bond_value;
  } psd_req_t;

  typedef struct packed {
    logic signed [63:0] descriptor_value;
    logic [63:0]        norm_sum;
    logic               saturated;
    logic               index_error;
  } psd_res_t;

endpackage

// ----- rtl/power_spectrum_descriptor_core.sv -----
// power_spectrum_descriptor_core: bond store, descriptor store, compute sequencer
// and output register of the power spectrum descriptor engine
// depends on psd_pkg
//
//   channel | signals                                   | direction
//   in      | in_valid_i, in_ready_o, in_i              | request in
//   out     | out_valid_o, out_ready_i, out_o           | result out
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,    | register write
//           | cfg_data_i                                |
//
// write requests may follow back to back while the core is idle
// a read passes through the descriptor memory port and the result register to the output
// a compute walks every term through the shared bond memory read pair and the product
// multiplier, squares each term into the norm, then passes S_CFIN and S_EMIT
// reset clears control, norm and flag and sets configuration to its defaults; memories are not cleared
// a waiting result holds the next read or compute and, with it, every request
module power_spectrum_descriptor_core #(
  parameter int unsigned MAX_RADIAL = 16,
  parameter int unsigned MAX_DEGREE = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  psd_pkg::psd_req_t                 in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output psd_pkg::psd_res_t                 out_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [psd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [psd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import psd_pkg::*;

  localparam int unsigned BOND_DEPTH = MAX_RADIAL * (MAX_DEGREE + 1) * (MAX_DEGREE + 1);
  localparam int unsigned DESC_DEPTH = (MAX_RADIAL * (MAX_RADIAL + 1) / 2) * (MAX_DEGREE + 1);
  localparam int unsigned BOND_AW = (BOND_DEPTH > 1) ? $clog2(BOND_DEPTH) : 1;
  localparam int unsigned DESC_AW = (DESC_DEPTH > 1) ? $clog2(DESC_DEPTH) : 1;
  localparam int unsigned BEXT_W = (BOND_AW > 10) ? BOND_AW : 10;
  localparam int unsigned DEXT_W = (DESC_AW > 10) ? DESC_AW : 10;
  localparam int unsigned ACC_W = 65 + $clog2(2 * MAX_DEGREE + 2);
  localparam int unsigned R_RST = (MAX_RADIAL < 16) ? MAX_RADIAL : 16;
  localparam int unsigned L_RST = (MAX_DEGREE < 3) ? MAX_DEGREE : 3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDATA,
    S_EMIT,
    S_PROD,
    S_TERM,
    S_SQ0,
    S_SQ1,
    S_SQ2,
    S_SQ3,
    S_NEXT,
    S_CFIN
  } state_e;

  state_e state_q;

  logic [4:0] eff_r_q;
  logic [1:0] eff_l_q;

  logic [63:0] norm_q;
  logic        sat_q;

  psd_res_t res_q;
  psd_res_t out_q;
  logic     out_valid_q;
  logic     rd_err_q;

  // compute sequencer
  logic [4:0]         n1_q, n2_q;
  logic [1:0]         l_q;
  logic [2:0]         m_q;
  logic [4:0]         h_q;
  logic [BOND_AW-1:0] base1_q, base2_q, lbase_q;
  logic [DESC_AW-1:0] desc_idx_q;
  logic               issuing_q;
  logic               rd_v_q, rd_last_q;
  logic               prod_v_q, prod_last_q;
  logic signed [63:0] prod_q;
  logic signed [ACC_W-1:0] sum_q;
  logic [63:0]        mag_q;
  logic [63:0]        sqp_q;
  logic [NORM_W-1:0]  nacc_q;
  logic               nsat_q;

  // memories
  logic signed [31:0] bond_mem [BOND_DEPTH];
  logic [63:0]        desc_mem [DESC_DEPTH];
  logic signed [31:0] brd1_q, brd2_q;
  logic [63:0]        drd_q;

  logic               in_acc;
  logic [1:0]         op;
  logic [BEXT_W-1:0]  baddr_ext;
  logic [DEXT_W-1:0]  daddr_ext;
  logic               bwe;
  logic               bre;
  logic [BOND_AW-1:0] bra1, bra2;
  logic               dre;
  logic               dwe;
  logic               emit;
  logic [10:0]        pair_prod;
  logic [12:0]        desc_count;
  logic               rd_in_range;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-9:0] t_s;
  logic signed [63:0] term;
  logic [2:0]         nl;
  logic               last_l, last_n2, last_n1;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign in_acc    = in_valid_i && in_ready_o;
  assign op        = in_i.opcode;
  assign baddr_ext = BEXT_W'(in_i.address);
  assign daddr_ext = DEXT_W'(in_i.address);

  assign pair_prod   = (11'(eff_r_q) * (11'(eff_r_q) + 11'd1)) >> 1;
  assign desc_count  = 13'(pair_prod) * (13'(eff_l_q) + 13'd1);
  assign rd_in_range = (13'(in_i.address) < desc_count);

  assign bwe  = in_acc && (op == OP_WRITE) && (32'(in_i.address) < 32'(BOND_DEPTH));
  assign bre  = (state_q == S_PROD) && issuing_q;
  assign bra1 = base1_q + lbase_q + BOND_AW'(m_q);
  assign bra2 = base2_q + lbase_q + BOND_AW'(m_q);
  assign dre  = in_acc && (op == OP_READ) && rd_in_range;
  assign dwe  = (state_q == S_TERM);
  assign emit = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  // round half up from Q20.48 sum to Q24.40
  assign rnd  = sum_q + ACC_W'(128);
  assign t_s  = rnd[ACC_W-1:8];
  assign term = 64'(t_s);

  assign nl      = 3'(eff_l_q) + 3'd1;
  assign last_l  = (l_q == eff_l_q);
  assign last_n2 = (n2_q == eff_r_q - 5'd1);
  assign last_n1 = (n1_q == eff_r_q - 5'd1);

  always_ff @(posedge clk_i) begin
    if (bwe) begin
      bond_mem[baddr_ext[BOND_AW-1:0]] <= in_i.bond_value;
    end
    if (bre) begin
      brd1_q <= bond_mem[bra1];
      brd2_q <= bond_mem[bra2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dwe) begin
      desc_mem[desc_idx_q] <= term;
    end
    if (dre) begin
      drd_q <= desc_mem[daddr_ext[DESC_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      eff_r_q     <= 5'(R_RST);
      eff_l_q     <= 2'(L_RST);
      norm_q      <= '0;
      sat_q       <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      rd_err_q    <= 1'b0;
      n1_q        <= '0;
      n2_q        <= '0;
      l_q         <= '0;
      m_q         <= '0;
      h_q         <= '0;
      base1_q     <= '0;
      base2_q     <= '0;
      lbase_q     <= '0;
      desc_idx_q  <= '0;
      issuing_q   <= 1'b0;
      rd_v_q      <= 1'b0;
      rd_last_q   <= 1'b0;
      prod_v_q    <= 1'b0;
      prod_last_q <= 1'b0;
      prod_q      <= '0;
      sum_q       <= '0;
      mag_q       <= '0;
      sqp_q       <= '0;
      nacc_q      <= '0;
      nsat_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_RADIAL) begin
          if (cfg_data_i == '0) begin
            eff_r_q <= 5'd1;
          end else if (32'(cfg_data_i) > 32'(MAX_RADIAL)) begin
            eff_r_q <= 5'(MAX_RADIAL);
          end else begin
            eff_r_q <= cfg_data_i;
          end
        end else if (cfg_index_i == CFG_DEGREE) begin
          if (32'(cfg_data_i[1:0]) > 32'(MAX_DEGREE)) begin
            eff_l_q <= 2'(MAX_DEGREE);
          end else begin
            eff_l_q <= cfg_data_i[1:0];
          end
        end
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (op)
              OP_COMPUTE: begin
                n1_q       <= '0;
                n2_q       <= '0;
                l_q        <= '0;
                m_q        <= '0;
                h_q        <= 5'(nl) * 5'(nl);
                base1_q    <= '0;
                base2_q    <= '0;
                lbase_q    <= '0;
                desc_idx_q <= '0;
                issuing_q  <= 1'b1;
                rd_v_q     <= 1'b0;
                prod_v_q   <= 1'b0;
                sum_q      <= '0;
                nacc_q     <= '0;
                nsat_q     <= 1'b0;
                state_q    <= S_PROD;
              end
              OP_READ: begin
                rd_err_q <= !rd_in_range;
                state_q  <= S_RDATA;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end

        S_RDATA: begin
          res_q.descriptor_value <= rd_err_q ? '0 : drd_q;
          res_q.norm_sum         <= norm_q;
          res_q.saturated        <= sat_q;
          res_q.index_error      <= rd_err_q;
          state_q                <= S_EMIT;
        end

        S_EMIT: begin
          if (emit) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end

        S_PROD: begin
          // issue, multiply and accumulate stages of the product pipeline
          rd_v_q <= issuing_q;
          if (issuing_q) begin
            rd_last_q <= (m_q == {l_q, 1'b0});
            m_q       <= m_q + 3'd1;
            if (m_q == {l_q, 1'b0}) begin
              issuing_q <= 1'b0;
            end
          end
          prod_v_q    <= rd_v_q;
          prod_last_q <= rd_last_q;
          if (rd_v_q) begin
            prod_q <= 64'(brd1_q) * 64'(brd2_q);
          end
          if (prod_v_q) begin
            sum_q <= sum_q + ACC_W'(prod_q);
            if (prod_last_q) begin
              state_q <= S_TERM;
            end
          end
        end

        S_TERM: begin
          mag_q   <= term[63] ? 64'(-term) : 64'(term);
          state_q <= S_SQ0;
        end

        S_SQ0: begin
          sqp_q   <= 64'(mag_q[31:0]) * 64'(mag_q[31:0]);
          state_q <= S_SQ1;
        end

        S_SQ1: begin
          if (!nsat_q) begin
            nacc_q <= nacc_q + NORM_W'(sqp_q);
          end
          sqp_q   <= 64'(mag_q[31:0]) * 64'(mag_q[63:32]);
          state_q <= S_SQ2;
        end

        S_SQ2: begin
          // cross term counts twice
          if (!nsat_q) begin
            nacc_q <= nacc_q + NORM_W'({sqp_q, 33'b0});
          end
          sqp_q   <= 64'(mag_q[63:32]) * 64'(mag_q[63:32]);
          state_q <= S_SQ3;
        end

        S_SQ3: begin
          if (!nsat_q) begin
            nacc_q <= nacc_q + NORM_W'({sqp_q, 64'b0});
          end
          state_q <= S_NEXT;
        end

        S_NEXT: begin
          if (nacc_q[NORM_W-1:NORM_SAT] != '0) begin
            nsat_q <= 1'b1;
          end
          desc_idx_q <= desc_idx_q + DESC_AW'(1);
          m_q        <= '0;
          sum_q      <= '0;
          rd_v_q     <= 1'b0;
          prod_v_q   <= 1'b0;
          issuing_q  <= 1'b1;
          state_q    <= S_PROD;
          if (!last_l) begin
            l_q     <= l_q + 2'd1;
            lbase_q <= lbase_q + BOND_AW'({l_q, 1'b1});
          end else begin
            l_q     <= '0;
            lbase_q <= '0;
            if (!last_n2) begin
              n2_q    <= n2_q + 5'd1;
              base2_q <= base2_q + BOND_AW'(h_q);
            end else if (!last_n1) begin
              n1_q    <= n1_q + 5'd1;
              n2_q    <= n1_q + 5'd1;
              base1_q <= base1_q + BOND_AW'(h_q);
              base2_q <= base1_q + BOND_AW'(h_q);
            end else begin
              issuing_q <= 1'b0;
              state_q   <= S_CFIN;
            end
          end
        end

        S_CFIN: begin
          norm_q                 <= nsat_q ? '1 : nacc_q[NORM_SAT-1:48];
          sat_q                  <= nsat_q;
          res_q.descriptor_value <= '0;
          res_q.norm_sum         <= nsat_q ? '1 : nacc_q[NORM_SAT-1:48];
          res_q.saturated        <= nsat_q;
          res_q.index_error      <= 1'b0;
          state_q                <= S_EMIT;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
